@@ hdl/acbc_pkg.sv @@
// ============================================================================
// acbc_pkg
// Shared types, constants and AES round functions for the CBC codec.
// ============================================================================
package acbc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_ROUNDS  = 10;
    localparam int RK_ROWS     = NUM_ROUNDS + 1;
    localparam int RK_AW       = $clog2(RK_ROWS);

    typedef logic [127:0]     t_block;
    typedef logic [7:0]       t_byte;
    typedef logic [RK_AW-1:0] t_rk_addr;
    typedef logic [7:0]       t_byte_tab [256];

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_DECRYPT  = 2'd2
    } t_cfg_idx;

    // key schedule control, top to key store
    typedef struct packed {
        logic     start;
        t_rk_addr rd_addr;
    } t_ks_ctl;

    localparam t_byte_tab SBOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // inverse table built at elaboration from the forward one
    function automatic t_byte_tab f_make_inv();
        t_byte_tab t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = t_byte'(i);
        end
        return t;
    endfunction

    localparam t_byte_tab INV_SBOX = f_make_inv();

    function automatic t_byte f_xt(t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block f_sub(t_block s, logic inv);
        t_block o;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            o[8*i +: 8] = inv ? INV_SBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
        end
        return o;
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic t_block f_shift(t_block s, logic inv);
        t_block o;
        int src;
        int dst;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    dst = ((c + r) & 3) * 4 + r;
                    src = c * 4 + r;
                end else begin
                    dst = c * 4 + r;
                    src = ((c + r) & 3) * 4 + r;
                end
                o[127 - 8*dst -: 8] = s[127 - 8*src -: 8];
            end
        end
        return o;
    endfunction

    function automatic t_block f_mix(t_block s, logic inv);
        t_block o;
        t_byte  a [4];
        t_byte  x2 [4];
        t_byte  x4 [4];
        t_byte  x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127 - 8*(4*c + k) -: 8];
                x2[k] = f_xt(a[k]);
                x4[k] = f_xt(x2[k]);
                x8[k] = f_xt(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127 - 8*(4*c + r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3]) ^
                        (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3]) ^
                        (x8[(r+3)&3] ^ a[(r+3)&3]);
                end else begin
                    o[127 - 8*(4*c + r) -: 8] =
                        x2[r] ^ (x2[(r+1)&3] ^ a[(r+1)&3]) ^
                        a[(r+2)&3] ^ a[(r+3)&3];
                end
            end
        end
        return o;
    endfunction

endpackage

@@ hdl/acbc_ifs.sv @@
// ============================================================================
// acbc interfaces
// Input, result and configuration channels of the CBC codec.
// ============================================================================
interface acbc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  valid_bytes;
    logic        last_block;

    modport source (output valid, op, data_hi, data_lo, valid_bytes, last_block,
                    input ready);
    modport sink   (input valid, op, data_hi, data_lo, valid_bytes, last_block,
                    output ready);
endinterface

interface acbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_valid_bytes;
    logic        out_last;
    logic        pad_error;

    modport source (output valid, out_hi, out_lo, out_valid_bytes, out_last, pad_error,
                    input ready);
    modport sink   (input valid, out_hi, out_lo, out_valid_bytes, out_last, pad_error,
                    output ready);
endinterface

interface acbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/acbc_keysched.sv @@
// ============================================================================
// acbc_keysched
// Round key memory with a one-row-per-cycle expansion engine.
// ============================================================================
module acbc_keysched (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  acbc_pkg::t_block       i_key,
    input  acbc_pkg::t_ks_ctl      i_ctl,
    output logic                   o_busy,
    output acbc_pkg::t_block       o_rd_data
);
    import acbc_pkg::*;

    t_block   r_mem [RK_ROWS];
    t_block   r_rk;
    t_byte    r_rcon;
    t_rk_addr r_idx;
    logic     r_busy;
    t_block   r_rd;
    t_block   n_rk;
    logic [31:0] w_rot;
    logic [31:0] w_t;

    always_comb begin
        w_rot = {r_rk[23:0], r_rk[31:24]};
        w_t   = {SBOX[w_rot[31:24]] ^ r_rcon, SBOX[w_rot[23:16]],
                 SBOX[w_rot[15:8]], SBOX[w_rot[7:0]]};
        n_rk[127:96] = r_rk[127:96] ^ w_t;
        n_rk[95:64]  = r_rk[95:64] ^ n_rk[127:96];
        n_rk[63:32]  = r_rk[63:32] ^ n_rk[95:64];
        n_rk[31:0]   = r_rk[31:0] ^ n_rk[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_rk   <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_rk   <= n_rk;
            r_rcon <= f_xt(r_rcon);
            r_idx  <= r_idx + 1'b1;
            if (r_idx == t_rk_addr'(NUM_ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_idx] <= r_rk;
        end
        r_rd <= r_mem[i_ctl.rd_addr];
    end

    assign o_busy    = r_busy;
    assign o_rd_data = r_rd;

endmodule

@@ hdl/acbc_round.sv @@
// ============================================================================
// acbc_round
// One AES round, forward or inverse, selected per cycle.
// ============================================================================
module acbc_round (
    input  acbc_pkg::t_block i_state,
    input  acbc_pkg::t_block i_key,
    input  logic             i_decrypt,
    input  logic             i_final,
    output acbc_pkg::t_block o_state
);
    import acbc_pkg::*;

    t_block w_enc;
    t_block w_dec;

    always_comb begin
        w_enc = f_shift(f_sub(i_state, 1'b0), 1'b0);
        if (!i_final) begin
            w_enc = f_mix(w_enc, 1'b0);
        end
        w_enc = w_enc ^ i_key;

        // inverse order: shift, sub, key, then mix
        w_dec = f_sub(f_shift(i_state, 1'b1), 1'b1) ^ i_key;
        if (!i_final) begin
            w_dec = f_mix(w_dec, 1'b1);
        end
    end

    assign o_state = i_decrypt ? w_dec : w_enc;

endmodule

@@ hdl/aes128_cbc_pkcs7_codec_top.sv @@
// ============================================================================
// aes128_cbc_pkcs7_codec_top
// AES-128 CBC codec with PKCS#7 padding, one 16-byte block per transaction.
// ============================================================================
// Usage:
//   i_cfg  : register writes (0 key high, 1 key low, 2 decrypt mode); write
//            only while the block is idle. A key write marks the round key
//            memory stale; the next data block re-expands it first.
//   i_in   : op 0 loads the IV (echoed as a result when encrypting), op 1
//            carries a data block; last_block closes the message.
//   o_out  : result blocks, plus valid byte count and pad error on decrypt.
// Steps: a data block goes from acceptance through the load state, which
//   fetches a key row, and 11 round steps (key add, then rounds through
//   the shared round unit fed by the key memory read port) to the result
//   register; after a key change it first waits in the key state while
//   the key memory fills. A full final encrypt block runs the round loop
//   twice and yields two results. A new item is accepted only when idle,
//   not mid-item, but while a prior result sits in the output register.
// Reset: synchronous, active low; chaining value cleared, key and mode zero,
//   key memory marked stale. No clearing pass is needed.
// Stall: a held result blocks the next finish; the block waits in its
//   finish state until the output register frees.
// ============================================================================
module aes128_cbc_pkcs7_codec_top (
    input logic        i_clk,
    input logic        i_rst_n,
    acbc_cfg_if.sink   i_cfg,
    acbc_in_if.sink    i_in,
    acbc_out_if.source o_out
);
    import acbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_LOAD,
        S_RUN,
        S_FIN
    } t_state;

    t_state   r_state;
    logic [63:0] r_key_hi;
    logic [63:0] r_key_lo;
    logic     r_dec_mode;
    logic     r_key_stale;
    t_block   r_chain;

    // item context
    t_block   r_st;
    t_block   r_ct;
    logic     r_dec;
    logic     r_last;
    logic     r_two;
    logic     r_iv;
    logic [3:0] r_cnt;

    // output register
    logic     r_ovalid;
    t_block   r_out;
    logic [4:0] r_out_vb;
    logic     r_out_last;
    logic     r_out_err;

    logic     w_accept;
    logic     w_cfg_wr;
    logic     w_key_wr;
    logic     w_out_free;
    t_block   w_in_blk;
    t_block   n_pad_blk;
    logic [4:0] w_vbs;
    t_byte    w_pad;
    t_block   w_round;
    t_block   w_plain;
    t_byte    w_dpad;
    logic     w_dpad_bad;
    logic [4:0] w_dvb;
    t_block   w_dzero;
    t_block   w_fill16;
    t_ks_ctl  w_ks;
    logic     w_ks_busy;
    t_block   w_rk;
    logic     w_final_rnd;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cfg_wr   = i_cfg.valid && i_cfg.ready;
    assign w_key_wr   = w_cfg_wr &&
                        (i_cfg.index == CFG_KEY_HIGH || i_cfg.index == CFG_KEY_LOW);
    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_blk   = {i_in.data_hi, i_in.data_lo};
    assign w_final_rnd = (r_cnt == 4'(NUM_ROUNDS));

    // encrypt padding: bytes from the valid count on take the pad value
    always_comb begin
        w_vbs = (i_in.valid_bytes > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : i_in.valid_bytes;
        w_pad = t_byte'(5'(BLOCK_BYTES) - w_vbs);
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            n_pad_blk[127 - 8*i -: 8] = (5'(i) < w_vbs || !i_in.last_block) ?
                                        w_in_blk[127 - 8*i -: 8] : w_pad;
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            w_fill16[8*i +: 8] = t_byte'(BLOCK_BYTES);
        end
    end

    // decrypt padding check on the final block
    always_comb begin
        w_plain    = r_st ^ r_chain;
        w_dpad     = w_plain[7:0];
        w_dpad_bad = (w_dpad == 8'd0) || (w_dpad > t_byte'(BLOCK_BYTES));
        w_dvb      = 5'(BLOCK_BYTES) - w_dpad[4:0];
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            w_dzero[127 - 8*i -: 8] = (5'(i) >= w_dvb) ? 8'h00 : w_plain[127 - 8*i -: 8];
        end
    end

    // key row fetch: present the row needed on the next step
    always_comb begin
        w_ks.start = w_accept && i_in.op && r_key_stale;
        w_ks.rd_addr = '0;
        if (r_state == S_LOAD) begin
            w_ks.rd_addr = r_dec ? t_rk_addr'(NUM_ROUNDS) : '0;
        end else if (r_state == S_RUN && !w_final_rnd) begin
            w_ks.rd_addr = r_dec ? t_rk_addr'(4'(NUM_ROUNDS) - r_cnt - 4'd1)
                                 : t_rk_addr'(r_cnt + 4'd1);
        end
    end

    acbc_keysched u_keysched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    ({r_key_hi, r_key_lo}),
        .i_ctl    (w_ks),
        .o_busy   (w_ks_busy),
        .o_rd_data(w_rk)
    );

    acbc_round u_round (
        .i_state  (r_st),
        .i_key    (w_rk),
        .i_decrypt(r_dec),
        .i_final  (w_final_rnd),
        .o_state  (w_round)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_hi    <= '0;
            r_key_lo    <= '0;
            r_dec_mode  <= 1'b0;
            r_key_stale <= 1'b1;
            r_chain     <= '0;
            r_ovalid    <= 1'b0;
            r_cnt       <= '0;
            r_two       <= 1'b0;
            r_iv        <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (i_cfg.index)
                    CFG_KEY_HIGH: r_key_hi   <= i_cfg.data;
                    CFG_KEY_LOW:  r_key_lo   <= i_cfg.data;
                    CFG_DECRYPT:  r_dec_mode <= i_cfg.data[0];
                    default: ;
                endcase
            end
            // a key write in the start cycle keeps the memory stale
            if (w_key_wr) begin
                r_key_stale <= 1'b1;
            end else if (w_ks.start) begin
                r_key_stale <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_dec  <= r_dec_mode;
                        r_last <= i_in.last_block;
                        r_ct   <= w_in_blk;
                        if (!i_in.op) begin
                            r_chain <= w_in_blk;
                            r_st    <= w_in_blk;
                            r_iv    <= 1'b1;
                            if (!r_dec_mode) begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_iv  <= 1'b0;
                            r_two <= !r_dec_mode && i_in.last_block &&
                                     (w_vbs == 5'(BLOCK_BYTES));
                            r_st  <= r_dec_mode ? w_in_blk : (n_pad_blk ^ r_chain);
                            r_state <= r_key_stale ? S_KEY : S_LOAD;
                        end
                    end
                end
                S_KEY: begin
                    if (!w_ks_busy) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_st  <= (r_cnt == 4'd0) ? (r_st ^ w_rk) : w_round;
                    r_cnt <= r_cnt + 4'd1;
                    if (w_final_rnd) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        if (r_iv) begin
                            r_out      <= r_st;
                            r_out_vb   <= 5'(BLOCK_BYTES);
                            r_out_last <= 1'b0;
                            r_out_err  <= 1'b0;
                            r_state    <= S_IDLE;
                        end else if (!r_dec) begin
                            r_out      <= r_st;
                            r_out_vb   <= 5'(BLOCK_BYTES);
                            r_out_err  <= 1'b0;
                            r_out_last <= r_last && !r_two;
                            r_chain    <= r_st;
                            if (r_two) begin
                                // extra block of pad bytes after a full final block
                                r_two   <= 1'b0;
                                r_st    <= w_fill16 ^ r_st;
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_chain    <= r_ct;
                            r_out_last <= r_last;
                            r_state    <= S_IDLE;
                            if (r_last && !w_dpad_bad) begin
                                r_out     <= w_dzero;
                                r_out_vb  <= w_dvb;
                                r_out_err <= 1'b0;
                            end else begin
                                r_out     <= w_plain;
                                r_out_vb  <= 5'(BLOCK_BYTES);
                                r_out_err <= r_last;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.out_hi          = r_out[127:64];
    assign o_out.out_lo          = r_out[63:0];
    assign o_out.out_valid_bytes = r_out_vb;
    assign o_out.out_last        = r_out_last;
    assign o_out.pad_error       = r_out_err;

`ifndef SYNTHESIS
    // rounds never read the key memory while it is being refilled
    a_no_run_during_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_LOAD) |-> !w_ks_busy)
        else $error("round step while key expansion busy");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_out)))
        else $error("pending result overwritten");

    // round counter stays within the schedule
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= 4'(NUM_ROUNDS)))
        else $error("round counter out of range");
`endif

endmodule

@@ tb/sv/tb_aes128_cbc_pkcs7_codec_top.sv @@
// ============================================================================
// tb_aes128_cbc_pkcs7_codec_top
// Self-checking bench for the AES-128 CBC / PKCS#7 codec. A behavioral AES
// runs beside the block and predicts every result transaction. Stimulus is
// CBC messages (IV load plus data blocks) with stray blocks, random gaps and stalls.
// ============================================================================
module tb_aes128_cbc_pkcs7_codec_top;
    timeunit 1ns;
    timeprecision 1ps;
    import acbc_pkg::*;

    localparam bit OP_IV   = 1'b0;
    localparam bit OP_DATA = 1'b1;
    localparam int SETTLE_CYCLES = 40;        // key refill + round loop + margin
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        bit       op;
        t_block   data;
        bit [4:0] vbytes;
        bit       last;
    } t_cbc_item;

    typedef struct {
        t_block   data;
        bit [4:0] vbytes;
        bit       last;
        bit       err;
    } t_cbc_result;

    logic i_clk;
    logic i_rst_n;
    acbc_cfg_if cfg_if ();
    acbc_in_if  in_if ();
    acbc_out_if out_if ();

    aes128_cbc_pkcs7_codec_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // ------------------------------------------------------------------------
    // Behavioral AES, byte i of a block at bits [127-8i -: 8]
    // ------------------------------------------------------------------------
    t_byte fwd_sub [256];
    t_byte rev_sub [256];

    function automatic t_byte gmul(t_byte a, t_byte b);
        t_byte r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) r ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic t_byte rotl(t_byte x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // sbox from the GF(2^8) inverse and the affine map
    function automatic void build_sub_tables();
        t_byte p, r, b, s;
        for (int x = 0; x < 256; x++) begin
            p = t_byte'(x);
            r = 1;
            for (int i = 0; i < 7; i++) begin
                p = gmul(p, p);
                r = gmul(r, p);
            end
            b = r;
            s = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
            fwd_sub[x] = s;
            rev_sub[s] = t_byte'(x);
        end
    endfunction

    function automatic t_byte bget(t_block s, int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic void expand_key(t_block key, ref t_block rk [11]);
        logic [31:0] w [44];
        logic [31:0] t;
        t_byte rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if ((i & 3) == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic t_block sub_bytes(t_block s, bit inv);
        t_block o;
        for (int i = 0; i < 16; i++)
            o[127 - 8*i -: 8] = inv ? rev_sub[bget(s, i)] : fwd_sub[bget(s, i)];
        return o;
    endfunction

    function automatic t_block shift_rows(t_block s, bit inv);
        t_block o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) o[127 - 8*(((c + r) & 3)*4 + r) -: 8] = bget(s, c*4 + r);
                else     o[127 - 8*(c*4 + r) -: 8] = bget(s, ((c + r) & 3)*4 + r);
            end
        end
        return o;
    endfunction

    function automatic t_block mix_columns(t_block s, bit inv);
        t_block o;
        t_byte m [4];
        t_byte v;
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 0;
                for (int k = 0; k < 4; k++) v ^= gmul(m[(k - r + 4) & 3], bget(s, 4*c + k));
                o[127 - 8*(4*c + r) -: 8] = v;
            end
        end
        return o;
    endfunction

    function automatic t_block blk_encrypt(t_block s, t_block key);
        t_block rk [11];
        expand_key(key, rk);
        s ^= rk[0];
        for (int r = 1; r <= 10; r++) begin
            s = shift_rows(sub_bytes(s, 0), 0);
            if (r != 10) s = mix_columns(s, 0);
            s ^= rk[r];
        end
        return s;
    endfunction

    function automatic t_block blk_decrypt(t_block s, t_block key);
        t_block rk [11];
        expand_key(key, rk);
        s ^= rk[10];
        for (int r = 9; r >= 0; r--) begin
            s = sub_bytes(shift_rows(s, 1), 1);
            s ^= rk[r];
            if (r != 0) s = mix_columns(s, 1);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor state: configuration copy and CBC chaining block
    // ------------------------------------------------------------------------
    t_block      key_cfg;
    bit          decrypt_cfg;
    t_block      chain_blk;
    t_cbc_item   input_items [$];
    t_cbc_result expected_blocks [$];
    int          fail_cnt;
    int          rx_cnt;

    function automatic void push_result(t_block d, int vb, bit last, bit err);
        t_cbc_result r;
        r.data   = d;
        r.vbytes = vb[4:0];
        r.last   = last;
        r.err    = err;
        expected_blocks.push_back(r);
    endfunction

    // one accepted input transaction -> zero, one or two expected results
    function automatic void cbc_step(t_cbc_item it);
        t_block s, c;
        int vb, pad;
        if (it.op == OP_IV) begin
            chain_blk = it.data;
            if (!decrypt_cfg) push_result(it.data, 16, 0, 0);
        end else if (!decrypt_cfg) begin
            s = it.data;
            if (!it.last) begin
                chain_blk = blk_encrypt(s ^ chain_blk, key_cfg);
                push_result(chain_blk, 16, 0, 0);
            end else begin
                vb = (it.vbytes > 16) ? 16 : it.vbytes;
                if (vb < 16) begin
                    for (int i = vb; i < 16; i++) s[127 - 8*i -: 8] = t_byte'(16 - vb);
                    chain_blk = blk_encrypt(s ^ chain_blk, key_cfg);
                    push_result(chain_blk, 16, 1, 0);
                end else begin
                    // full final block: data, then a whole block of padding
                    chain_blk = blk_encrypt(s ^ chain_blk, key_cfg);
                    push_result(chain_blk, 16, 0, 0);
                    chain_blk = blk_encrypt({16{8'h10}} ^ chain_blk, key_cfg);
                    push_result(chain_blk, 16, 1, 0);
                end
            end
        end else begin
            c = chain_blk;
            s = blk_decrypt(it.data, key_cfg) ^ c;
            chain_blk = it.data;
            if (!it.last) begin
                push_result(s, 16, 0, 0);
            end else begin
                pad = s[7:0];
                if (pad == 0 || pad > 16) begin
                    push_result(s, 16, 1, 1);
                end else begin
                    for (int i = 16 - pad; i < 16; i++) s[127 - 8*i -: 8] = 8'h00;
                    push_result(s, 16 - pad, 1, 0);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    int cycle_cnt;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** aes128_cbc_pkcs7_codec_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input driver: offers the head of input_items, pops it on a transaction
    // ------------------------------------------------------------------------
    int send_gap;
    int calm_left;   // stretch with no idling at all

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)  calm_left = $urandom_range(20, 80);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                cbc_step(input_items.pop_front());
                send_gap = pick_gap();
            end
            if (in_if.valid && !in_if.ready) begin
                // hold the offered transaction
            end else if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (input_items.size() > 0) begin
                in_if.valid       <= 1'b1;
                in_if.op          <= input_items[0].op;
                in_if.data_hi     <= input_items[0].data[127:64];
                in_if.data_lo     <= input_items[0].data[63:0];
                in_if.valid_bytes <= input_items[0].vbytes;
                in_if.last_block  <= input_items[0].last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: random stalls, one long hold-off to back the block up
    // ------------------------------------------------------------------------
    int  stall_left;
    bit  long_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (!long_hold_done && rx_cnt >= 60) begin
                long_hold_done = 1'b1;
                stall_left = 600;
            end else if (stall_left == 0 && calm_left == 0) begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:  stall_left = 0;
                    [70:96]: stall_left = $urandom_range(1, 3);
                    default: stall_left = $urandom_range(15, 50);
                endcase
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every transaction against the oldest expectation
    // ------------------------------------------------------------------------
    t_cbc_result exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rx_cnt++;
            if (expected_blocks.size() == 0) begin
                $error("unexpected result transaction hi=%h lo=%h",
                       out_if.out_hi, out_if.out_lo);
                fail_cnt++;
            end else begin
                exp_r = expected_blocks.pop_front();
                if (out_if.out_hi !== exp_r.data[127:64]) begin
                    $error("out_hi exp %h got %h", exp_r.data[127:64], out_if.out_hi);
                    fail_cnt++;
                end
                if (out_if.out_lo !== exp_r.data[63:0]) begin
                    $error("out_lo exp %h got %h", exp_r.data[63:0], out_if.out_lo);
                    fail_cnt++;
                end
                if (out_if.out_valid_bytes !== exp_r.vbytes) begin
                    $error("out_valid_bytes exp %0d got %0d", exp_r.vbytes,
                           out_if.out_valid_bytes);
                    fail_cnt++;
                end
                if (out_if.out_last !== exp_r.last) begin
                    $error("out_last exp %0b got %0b", exp_r.last, out_if.out_last);
                    fail_cnt++;
                end
                if (out_if.pad_error !== exp_r.err) begin
                    $error("pad_error exp %0b got %0b", exp_r.err, out_if.pad_error);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_block rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic void add_item(bit op, t_block d, bit [4:0] vb, bit last);
        t_cbc_item it;
        it.op     = op;
        it.data   = d;
        it.vbytes = vb;
        it.last   = last;
        input_items.push_back(it);
    endfunction

    // register write transaction, only while the block is idle; valid is
    // left high so writes can follow back to back, the caller drops it
    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_KEY_HIGH: key_cfg[127:64] = val;
            CFG_KEY_LOW:  key_cfg[63:0]   = val;
            CFG_DECRYPT:  decrypt_cfg     = val[0];
            default: ;
        endcase
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(posedge i_clk);
        while (input_items.size() != 0 || in_if.valid || expected_blocks.size() != 0);
    endtask

    task automatic set_mode(t_block key, bit dec);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);   // IV loads in decrypt give no result
        write_reg(CFG_KEY_HIGH, key[127:64]);
        write_reg(CFG_KEY_LOW, key[63:0]);
        write_reg(CFG_DECRYPT, {63'd0, dec});
        cfg_if.valid <= 1'b0;
    endtask

    function automatic bit [4:0] rand_vb();
        return ($urandom_range(0, 4) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
    endfunction

    // one well-formed message; when decrypting, the blocks are real CBC
    // ciphertext so that the padding check passes
    function automatic int add_message(t_block key, bit dec);
        t_block iv, ch, p;
        int nblk, vb, cnt;
        iv = rand_block();
        add_item(OP_IV, iv, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        cnt = 1;
        nblk = $urandom_range(1, 4);
        ch = iv;
        for (int k = 0; k < nblk; k++) begin
            p = rand_block();
            if (!dec) begin
                add_item(OP_DATA, p, (k == nblk - 1) ? rand_vb() : 5'($urandom_range(0, 31)),
                         k == nblk - 1);
                cnt++;
            end else if (k < nblk - 1) begin
                ch = blk_encrypt(p ^ ch, key);
                add_item(OP_DATA, ch, 5'($urandom_range(0, 31)), 1'b0);
                cnt++;
            end else begin
                vb = $urandom_range(0, 16);
                if (vb == 16) begin
                    ch = blk_encrypt(p ^ ch, key);
                    add_item(OP_DATA, ch, 5'($urandom_range(0, 31)), 1'b0);
                    p = {16{8'h10}};
                    cnt++;
                end else begin
                    for (int i = vb; i < 16; i++) p[127 - 8*i -: 8] = t_byte'(16 - vb);
                end
                ch = blk_encrypt(p ^ ch, key);
                add_item(OP_DATA, ch, 5'($urandom_range(0, 31)), 1'b1);
                cnt++;
            end
        end
        return cnt;
    endfunction

    task automatic random_phase(t_block key, bit dec, int n_items);
        int sent;
        sent = 0;
        set_mode(key, dec);
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: stray data block, no IV, random last flag
                add_item(OP_DATA, rand_block(), 5'($urandom_range(0, 31)),
                         1'($urandom_range(0, 1)));
                sent++;
            end else begin
                sent += add_message(key, dec);
            end
            if ($urandom_range(0, 29) == 0) wait_drained();
            else @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        build_sub_tables();
        key_cfg      = '0;
        decrypt_cfg  = 1'b0;
        chain_blk    = '0;
        fail_cnt     = 0;
        rx_cnt       = 0;
        cycle_cnt    = 0;
        send_gap     = 0;
        calm_left    = 0;
        stall_left   = 0;
        long_hold_done = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_KEY_HIGH;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        in_if.op     = OP_IV;
        in_if.data_hi = '0;
        in_if.data_lo = '0;
        in_if.valid_bytes = '0;
        in_if.last_block  = 1'b0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset key and mode: data before any IV chains from zero,
        // extremes of data and of valid_bytes on the final block
        add_item(OP_DATA, '1, 5'd0, 1'b0);
        add_item(OP_DATA, '0, 5'd31, 1'b1);
        add_item(OP_IV, '0, 5'd0, 1'b0);
        add_item(OP_DATA, '1, 5'd3, 1'b0);
        add_item(OP_DATA, '0, 5'd0, 1'b1);
        add_item(OP_IV, '1, 5'd31, 1'b1);
        add_item(OP_DATA, rand_block(), 5'd16, 1'b1);
        add_item(OP_IV, rand_block(), 5'd0, 1'b0);
        add_item(OP_DATA, rand_block(), 5'd17, 1'b1);
        add_item(OP_DATA, rand_block(), 5'd15, 1'b1);
        add_item(OP_DATA, rand_block(), 5'd1, 1'b1);
        add_item(OP_DATA, '0, 5'd5, 1'b1);
        wait_drained();

        random_phase('0, 1'b0, 300);
        random_phase('1, 1'b1, 330);
        random_phase(rand_block(), 1'b0, 330);
        random_phase(rand_block(), 1'b1, 330);
        random_phase('1, 1'b0, 330);
        random_phase('0, 1'b1, 330);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("** aes128_cbc_pkcs7_codec_top: PASSED **");
        end else begin
            $display("** aes128_cbc_pkcs7_codec_top: FAILED **");
        end
        $finish;
    end

endmodule
